// ----- design/arm_command_line_parser_top_assert.svh -----
// Assertion macros shared by the parser and the angle mapping stages.
// Each one expects clk, and ACL_ASSERT also rst_n, to be visible where it is used.
`ifndef ARM_COMMAND_LINE_PARSER_TOP_ASSERT_SVH
`define ARM_COMMAND_LINE_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define ACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define ACL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACL_ASSERT(lbl, prop, msg)
`define ACL_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- design/acl_pkg.sv -----
package acl_pkg;

  localparam int SERVO_COUNT = 6;
  // Angle outputs on the result channel.
  localparam int ANGLE_OUTS = 6;
  // Value slots: an arm line needs SERVO_COUNT of them, a laser line two.
  localparam int SLOTS = (SERVO_COUNT > 2) ? SERVO_COUNT : 2;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int NUM_W = 26;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_L     = 8'h6C;

  localparam logic [14:0] MAG_MAX  = 15'd32767;
  localparam logic [18:0] DEC_BASE = 19'd10;

  localparam logic CMD_ARM   = 1'b0;
  localparam logic CMD_LASER = 1'b1;

  // Calibration points per servo; entries past the sixth are identity.
  localparam int CAL_C0 [8] = '{90, 90, 155, 150, 90, 60, 90, 90};
  localparam int CAL_C1 [8] = '{160, 20, 90, 80, 30, 0, 180, 180};

  localparam logic [7:0] ANGLE_MAX = 8'd180;
  // Numerator at or above which the quotient by 90 clamps to the maximum.
  localparam logic signed [NUM_W-1:0] NUM_SAT = NUM_W'(90 * 180);
  // n / 90 == (n >> 1) / 45, and (x * 11651) >> 19 equals x / 45 for x < 74898.
  localparam logic [13:0] DIV_RECIP = 14'd11651;
  localparam int DIV_SHIFT = 19;

  typedef enum logic [1:0] {
    POS_CMD,
    POS_SKIP,
    POS_FIELDS
  } pos_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ARM,
    KIND_LASER
  } kind_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_OK,
    ST_FAIL
  } status_t;

  // A finished line as it leaves the parser.
  typedef struct packed {
    logic                         cmd_kind;
    logic [ANGLE_OUTS-1:0][15:0]  vals;
    logic [15:0]                  laser_channel;
    logic                         laser_on;
  } line_t;

  // Calibrated numerators, before the division by 90.
  typedef struct packed {
    logic                           cmd_kind;
    logic [ANGLE_OUTS-1:0][NUM_W-1:0] nums;
    logic [15:0]                    laser_channel;
    logic                           laser_on;
  } num_t;

endpackage

// ----- design/acl_rx_if.sv -----
interface acl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- design/acl_res_if.sv -----
interface acl_res_if;
  logic               valid;
  logic               ready;
  logic               cmd_kind;
  logic [7:0]         angle_0;
  logic [7:0]         angle_1;
  logic [7:0]         angle_2;
  logic [7:0]         angle_3;
  logic [7:0]         angle_4;
  logic [7:0]         angle_5;
  logic signed [15:0] laser_channel;
  logic               laser_on;

  modport source (output valid, output cmd_kind, output angle_0, output angle_1,
                  output angle_2, output angle_3, output angle_4, output angle_5,
                  output laser_channel, output laser_on, input ready);
  modport sink (input valid, input cmd_kind, input angle_0, input angle_1,
                input angle_2, input angle_3, input angle_4, input angle_5,
                input laser_channel, input laser_on, output ready);
endinterface

// ----- design/arm_command_line_parser_top.sv -----
// Arm command line parser. Takes one received character per beat on in_rx and
// can accept a beat on every clock while out_res does not stall. A successful
// line gives one beat on out_res after its newline is taken, registered in
// turn in the input register, in the line parser behind it, whose state update
// sets the one-byte-per-clock rate, in the calibration multiply and in the
// division by 90 and the clamp. Failed lines give no beat. Stalls on
// out_res back up through the stages and hold off in_rx only once every
// stage is full.
module arm_command_line_parser_top import acl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  acl_rx_if.sink    in_rx,
  acl_res_if.source out_res
);

  logic  line_valid;
  logic  line_ready;
  line_t line_data;

  acl_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_rx      (in_rx),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line_data  (line_data)
  );

  acl_map u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line_data  (line_data),
    .out_res    (out_res)
  );

endmodule

// ----- design/acl_parse.sv -----
`include "arm_command_line_parser_top_assert.svh"

module acl_parse import acl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  acl_rx_if.sink in_rx,
  output logic  line_valid,
  input  logic  line_ready,
  output line_t line_data
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       s1_ready;
  logic       s0_adv;

  pos_t               pos_r, pos_nxt;
  kind_t              kind_r, kind_nxt;
  status_t            status_r, status_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [14:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic               dig_r, dig_nxt;
  logic [SLOTS-1:0][15:0] vals_r, vals_nxt;

  logic       line_valid_r;
  line_t      line_r, line_nxt;
  logic       emit;
  logic       close_fld;
  logic       at_end;
  logic [CNT_W-1:0] needed;
  logic [3:0]  digit;
  logic [18:0] acc;
  logic [15:0] fld_val;

  assign s1_ready    = !line_valid_r || line_ready;
  assign s0_adv      = in_valid_r && s1_ready;
  assign in_rx.ready = !in_valid_r || s1_ready;
  assign line_valid  = line_valid_r;
  assign line_data   = line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_rx.ready) begin
      in_valid_r <= in_rx.valid;
    end
    if (in_rx.valid && in_rx.ready) begin
      in_byte_r <= in_rx.rx_byte;
    end
  end

  // Position along the line.
  always_comb begin
    pos_nxt = pos_r;
    if (in_byte_r == CH_NL) begin
      pos_nxt = POS_CMD;
    end else begin
      unique case (pos_r)
        POS_CMD:  pos_nxt = POS_SKIP;
        POS_SKIP: pos_nxt = POS_FIELDS;
        default:  pos_nxt = POS_FIELDS;
      endcase
    end
  end

  // Command, field scan and result assembly.
  always_comb begin
    kind_nxt   = kind_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    dig_nxt    = dig_r;
    vals_nxt   = vals_r;
    close_fld  = 1'b0;
    at_end     = 1'b0;
    emit       = 1'b0;
    needed     = (kind_r == KIND_ARM) ? CNT_W'(SERVO_COUNT) : CNT_W'(2);
    digit      = 4'(in_byte_r - CH_ZERO);
    acc        = 19'(mag_r) * DEC_BASE + 19'(digit);
    fld_val    = neg_r ? 16'(-{1'b0, mag_r}) : {1'b0, mag_r};

    if (in_byte_r == CH_NL) begin
      if (pos_r == POS_FIELDS && status_r == ST_COLLECT) begin
        close_fld = 1'b1;
        at_end    = 1'b1;
      end
    end else if (pos_r == POS_CMD) begin
      priority if (in_byte_r == CH_A) begin
        kind_nxt   = KIND_ARM;
        status_nxt = ST_COLLECT;
      end else if (in_byte_r == CH_L) begin
        kind_nxt   = KIND_LASER;
        status_nxt = ST_COLLECT;
      end else begin
        kind_nxt   = KIND_NONE;
        status_nxt = ST_FAIL;
      end
    end else if (pos_r == POS_FIELDS && status_r == ST_COLLECT) begin
      priority if (in_byte_r == CH_NUL || in_byte_r == CH_COMMA) begin
        close_fld = 1'b1;
        at_end    = (in_byte_r == CH_NUL);
      end else if (in_byte_r == CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (in_byte_r >= CH_ZERO && in_byte_r <= CH_NINE) begin
        mag_nxt = (acc > 19'(MAG_MAX)) ? MAG_MAX : acc[14:0];
        dig_nxt = 1'b1;
      end else begin
        status_nxt = ST_FAIL;
      end
    end

    if (close_fld) begin
      if (!dig_r) begin
        status_nxt = ST_FAIL;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (cnt_r == CNT_W'(i)) begin
            vals_nxt[i] = fld_val;
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        mag_nxt = '0;
        neg_nxt = 1'b0;
        dig_nxt = 1'b0;
        if (cnt_nxt >= needed) begin
          status_nxt = ST_OK;
        end else if (at_end) begin
          status_nxt = ST_FAIL;
        end
      end
    end

    line_nxt = '0;
    if (kind_r == KIND_LASER) begin
      line_nxt.cmd_kind      = CMD_LASER;
      line_nxt.laser_channel = vals_nxt[0];
      line_nxt.laser_on      = (vals_nxt[1] != '0);
    end else begin
      line_nxt.cmd_kind = CMD_ARM;
      for (int k = 0; k < ANGLE_OUTS; k++) begin
        if (k < SLOTS) begin
          line_nxt.vals[k] = vals_nxt[k];
        end
      end
    end

    if (in_byte_r == CH_NL) begin
      emit       = (pos_r == POS_FIELDS) && (status_nxt == ST_OK);
      kind_nxt   = KIND_NONE;
      status_nxt = ST_COLLECT;
      cnt_nxt    = '0;
      mag_nxt    = '0;
      neg_nxt    = 1'b0;
      dig_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_CMD;
      kind_r   <= KIND_NONE;
      status_r <= ST_COLLECT;
      cnt_r    <= '0;
      mag_r    <= '0;
      neg_r    <= 1'b0;
      dig_r    <= 1'b0;
    end else if (s0_adv) begin
      pos_r    <= pos_nxt;
      kind_r   <= kind_nxt;
      status_r <= status_nxt;
      cnt_r    <= cnt_nxt;
      mag_r    <= mag_nxt;
      neg_r    <= neg_nxt;
      dig_r    <= dig_nxt;
    end
    if (s0_adv) begin
      vals_r <= vals_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_valid_r <= 1'b0;
    end else if (s1_ready) begin
      line_valid_r <= s0_adv && emit;
    end
    if (s0_adv && emit) begin
      line_r <= line_nxt;
    end
  end

  `ACL_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(SLOTS), "Field count ran past the value slots.")
  `ACL_ASSERT(a_ok_in_fields, status_r == ST_OK |-> pos_r == POS_FIELDS, "Line succeeded outside the fields.")
  `ACL_ASSERT(a_nl_restarts, s0_adv && in_byte_r == CH_NL |=> pos_r == POS_CMD && cnt_r == '0, "Newline did not restart the line.")
  `ACL_ASSERT_RST(a_reset_empty, !rst_n |=> !in_valid_r && !line_valid_r, "Parser stages not empty after reset.")

endmodule

// ----- design/acl_map.sv -----
`include "arm_command_line_parser_top_assert.svh"

module acl_map import acl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  line_valid,
  output logic  line_ready,
  input  line_t line_data,
  acl_res_if.source out_res
);

  logic s2_ready;
  logic s3_ready;

  logic num_valid_r;
  num_t num_r, num_nxt;
  logic [NUM_W-1:0] lane_num [ANGLE_OUTS];

  logic                         out_valid_r;
  logic [ANGLE_OUTS-1:0][7:0]   ang_r, ang_nxt;
  logic                         out_kind_r;
  logic [15:0]                  out_ch_r;
  logic                         out_on_r;
  logic                         ang_in_range;

  assign s3_ready   = !out_valid_r || out_res.ready;
  assign s2_ready   = !num_valid_r || s3_ready;
  assign line_ready = s2_ready;

  // Numerator per servo: (c1 - c0) * v + 90 * (2 * c0 - c1).
  for (genvar k = 0; k < ANGLE_OUTS; k++) begin : g_lane
    if (k < SERVO_COUNT) begin : g_used
      localparam logic signed [8:0] SLOPE = 9'(CAL_C1[k] - CAL_C0[k]);
      localparam logic signed [NUM_W-1:0] OFS = NUM_W'(90 * (2 * CAL_C0[k] - CAL_C1[k]));
      logic signed [24:0] prod;
      assign prod        = 25'(SLOPE) * 25'($signed(line_data.vals[k]));
      assign lane_num[k] = NUM_W'(prod) + OFS;
    end else begin : g_unused
      assign lane_num[k] = '0;
    end
  end

  always_comb begin
    num_nxt               = '0;
    num_nxt.cmd_kind      = line_data.cmd_kind;
    num_nxt.laser_channel = line_data.laser_channel;
    num_nxt.laser_on      = line_data.laser_on;
    for (int k = 0; k < ANGLE_OUTS; k++) begin
      num_nxt.nums[k] = lane_num[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_valid_r <= 1'b0;
    end else if (s2_ready) begin
      num_valid_r <= line_valid;
    end
    if (s2_ready && line_valid) begin
      num_r <= num_nxt;
    end
  end

  // Truncating division by 90 with the clamp folded in: only numerators
  // strictly between zero and 90 * 180 need the quotient.
  always_comb begin
    logic signed [NUM_W-1:0] n;
    logic [12:0] half;
    logic [26:0] quot;
    ang_nxt      = '0;
    ang_in_range = 1'b1;
    for (int k = 0; k < ANGLE_OUTS; k++) begin
      n    = $signed(num_r.nums[k]);
      half = n[13:1];
      quot = 27'(half) * 27'(DIV_RECIP);
      priority if (n <= $signed(NUM_W'(0))) begin
        ang_nxt[k] = '0;
      end else if (n >= NUM_SAT) begin
        ang_nxt[k] = ANGLE_MAX;
      end else begin
        ang_nxt[k] = quot[DIV_SHIFT +: 8];
      end
      if (num_r.cmd_kind == CMD_LASER) begin
        ang_nxt[k] = '0;
      end
      if (ang_r[k] > ANGLE_MAX) begin
        ang_in_range = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= num_valid_r;
    end
    if (s3_ready && num_valid_r) begin
      ang_r      <= ang_nxt;
      out_kind_r <= num_r.cmd_kind;
      out_ch_r   <= num_r.laser_channel;
      out_on_r   <= num_r.laser_on;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.cmd_kind      = out_kind_r;
  assign out_res.angle_0       = ang_r[0];
  assign out_res.angle_1       = ang_r[1];
  assign out_res.angle_2       = ang_r[2];
  assign out_res.angle_3       = ang_r[3];
  assign out_res.angle_4       = ang_r[4];
  assign out_res.angle_5       = ang_r[5];
  assign out_res.laser_channel = $signed(out_ch_r);
  assign out_res.laser_on      = out_on_r;

  `ACL_ASSERT(a_angle_range, out_valid_r |-> ang_in_range, "Output angle above the clamp.")
  `ACL_ASSERT(a_laser_no_angle, out_valid_r && out_kind_r == CMD_LASER |-> ang_r == '0, "Laser beat carries angles.")
  `ACL_ASSERT(a_stage_moves, num_valid_r && s3_ready |=> out_valid_r, "Numerator stage lost a line.")
  `ACL_ASSERT_RST(a_reset_empty, !rst_n |=> !num_valid_r && !out_valid_r, "Mapping stages not empty after reset.")

endmodule
